@@ src/pobf_pkg.sv @@
// Package for the port obfuscation rewriter: constants, register indexes,
// pipeline record type and the small arithmetic helpers. No dependencies.
package pobf_pkg;

  localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
  localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;
  localparam logic [15:0] GHOST_MIN = 16'd1024;
  localparam logic [15:0] PORT_MAX  = 16'hFFFF;
  localparam logic [7:0]  SALT_SRC  = 8'h53;
  localparam logic [7:0]  SALT_DST  = 8'h44;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ST_REWRITTEN = 2'd0,
    ST_UNCHANGED = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_SRC_EN    = 3'd0,
    REG_DST_EN    = 3'd1,
    REG_TCP_ALIAS1 = 3'd2,
    REG_TCP_ALIAS2 = 3'd3,
    REG_UDP_ALIAS = 3'd4
  } reg_idx_t;

  // Everything an item carries down the pipe besides the hash words.
  typedef struct packed {
    logic        op;
    logic        se;
    logic        de;
    logic        go;
    logic        drop;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] osrc;
    logic [15:0] odst;
    logic [15:0] total;
    logic [15:0] l4;
    logic [15:0] tot_new;
    logic [15:0] udp_new;
    logic [31:0] tail;
    logic [2:0]  tb;
  } item_t;

  // Residue of a 22-bit value modulo 63 (64 is 1 mod 63, so fold 6-bit digits).
  function automatic logic [5:0] mod63(input logic [21:0] v);
    logic [7:0] s;
    logic [6:0] f;
    begin
      s = {2'b00, v[5:0]} + {2'b00, v[11:6]} + {2'b00, v[17:12]} + {4'b0000, v[21:18]};
      f = {5'b00000, s[7:6]} + {1'b0, s[5:0]};
      if (f >= 7'd63) f = f - 7'd63;
      mod63 = f[5:0];
    end
  endfunction

  // Ghost port from the final mixed word: 1024 + (v mod 64512), stepped off orig.
  function automatic logic [15:0] ghost_fin(input logic [31:0] v, input logic [15:0] orig);
    logic [15:0] g;
    begin
      g = {mod63(v[31:10]), v[9:0]} + GHOST_MIN;
      if (g == orig) g = (g == PORT_MAX) ? GHOST_MIN : g + 16'd1;
      ghost_fin = g;
    end
  endfunction

  function automatic logic [31:0] seed_of(input logic [15:0] orig, input logic [15:0] peer,
                                          input logic [31:0] sa, input logic [31:0] da,
                                          input logic [7:0] proto, input logic [7:0] salt);
    logic [31:0] s;
    begin
      s = {orig, peer} ^ sa ^ {da[24:0], da[31:25]} ^ {proto, 24'd0} ^ {16'd0, salt, 8'd0};
      seed_of = s ^ {16'd0, s[31:16]};
    end
  endfunction

endpackage

@@ src/port_obfuscation_rewriter.sv @@
// Port obfuscation rewriter top level: four-stage pipeline for one IPv4 header.
// Depends on pobf_pkg.
//
// One header request is taken in every clock cycle (busy is never raised) and
// its result appears on the out_ ports, marked by out_valid, once it has passed
// the stage A register, the two 32x32 hash multiplies, each of which owns a
// register stage, and the modulo and final compare stage.
// Results cannot be held off, so the pipe never stalls. Configuration writes
// are always taken (cfg_ready is high) and should arrive only while no request
// is in flight.
module port_obfuscation_rewriter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_ver_ihl,
  input  logic [15:0] in_frag_word,
  input  logic [15:0] in_ip_total_len,
  input  logic [7:0]  in_ip_proto,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_l4_word,
  input  logic [31:0] in_port_pair,
  input  logic [15:0] in_buf_len,
  input  logic [15:0] in_buf_room,
  input  logic [31:0] in_tail_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_src_port_out,
  output logic [15:0] out_dst_port_out,
  output logic [15:0] out_total_len_out,
  output logic [15:0] out_udp_len_out,
  output logic [31:0] out_tail_out,
  output logic [2:0]  out_tail_bytes,
  output logic        out_recalc_checksum
);
  import pobf_pkg::*;

  // Configuration registers.
  logic       se_r, de_r;
  logic [7:0] tcp_a1_r, tcp_a2_r, udp_a_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_r     <= 1'b0;
      de_r     <= 1'b0;
      tcp_a1_r <= PROTO_TCP;
      tcp_a2_r <= PROTO_TCP;
      udp_a_r  <= PROTO_UDP;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_EN:     se_r     <= cfg_data[0];
        REG_DST_EN:     de_r     <= cfg_data[0];
        REG_TCP_ALIAS1: tcp_a1_r <= cfg_data;
        REG_TCP_ALIAS2: tcp_a2_r <= cfg_data;
        REG_UDP_ALIAS:  udp_a_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: header checks, length arithmetic and hash seeds.
  logic        acc;
  logic [15:0] sport, dport, osrc, odst, so_seed, sp_seed, do_seed, dp_seed;
  logic [7:0]  proto;
  logic        is_tcp, is_udp;
  logic [2:0]  tl;
  logic [16:0] hl, tot17, l417, tl17, tcpl;
  logic        base_ok, ap_ok, ap_drop, rs_ok;
  item_t       a_nxt;

  assign acc   = start && !busy;
  assign sport = in_port_pair[31:16];
  assign dport = in_port_pair[15:0];

  always_comb begin
    is_tcp = (in_ip_proto == PROTO_TCP) || (in_ip_proto == tcp_a1_r) ||
             (in_ip_proto == tcp_a2_r);
    is_udp = !is_tcp && ((in_ip_proto == PROTO_UDP) || (in_ip_proto == udp_a_r));
    proto  = is_tcp ? PROTO_TCP : PROTO_UDP;
    tl     = {1'b0, ({1'b0, se_r} + {1'b0, de_r})} << 1;
    hl     = {11'd0, in_ver_ihl[3:0], 2'b00};
    tot17  = {1'b0, in_ip_total_len};
    l417   = {1'b0, in_l4_word};
    tl17   = {14'd0, tl};
    tcpl   = {l417[14:0], 2'b00};

    base_ok = (tl != 3'd0) && (in_buf_len >= 16'd20) && (in_ver_ihl[7:4] == 4'd4) &&
              (in_frag_word[13:0] == 14'd0) && (hl >= 17'd20) &&
              ({1'b0, in_buf_len} >= hl) && (tot17 >= hl) &&
              (in_ip_total_len <= in_buf_len) && (is_tcp || is_udp);

    if (is_tcp) begin
      ap_ok = (tot17 >= hl + 17'd20) && (l417 >= 17'd5) && (l417 <= 17'd15) &&
              (tot17 >= hl + tcpl);
      rs_ok = (tot17 >= hl + 17'd20) && (l417 >= 17'd5) && (l417 <= 17'd15) &&
              (tot17 >= hl + tcpl + tl17);
    end else begin
      ap_ok = (tot17 >= hl + 17'd8) && (l417 >= 17'd8) && (l417 <= tot17 - hl) &&
              (l417 <= 17'd65535 - tl17);
      rs_ok = (tot17 >= hl + 17'd8) && (l417 >= 17'd8 + tl17) && (l417 <= tot17 - hl);
    end
    rs_ok   = rs_ok && (tot17 >= hl + tl17);
    ap_drop = (tot17 > 17'd65535 - tl17) || ({1'b0, in_buf_room} < tot17 + tl17);

    // Originals as the restore tail carries them.
    if (se_r && de_r) begin
      osrc = in_tail_in[31:16];
      odst = in_tail_in[15:0];
    end else begin
      osrc = se_r ? in_tail_in[15:0] : sport;
      odst = de_r ? in_tail_in[15:0] : dport;
    end
    so_seed = in_op ? osrc : sport;
    sp_seed = in_op ? odst : dport;
    do_seed = sp_seed;
    dp_seed = so_seed;

    a_nxt.op    = in_op;
    a_nxt.se    = se_r;
    a_nxt.de    = de_r;
    a_nxt.go    = base_ok && (in_op ? rs_ok : (ap_ok && !ap_drop));
    a_nxt.drop  = base_ok && !in_op && ap_ok && ap_drop;
    a_nxt.sport = sport;
    a_nxt.dport = dport;
    a_nxt.osrc  = osrc;
    a_nxt.odst  = odst;
    a_nxt.total = in_ip_total_len;
    a_nxt.l4    = in_l4_word;
    a_nxt.tot_new = in_op ? in_ip_total_len - {13'd0, tl} : in_ip_total_len + {13'd0, tl};
    if (is_udp)
      a_nxt.udp_new = in_op ? in_l4_word - {13'd0, tl} : in_l4_word + {13'd0, tl};
    else
      a_nxt.udp_new = in_l4_word;
    if (in_op)                a_nxt.tail = 32'd0;
    else if (se_r && de_r)    a_nxt.tail = in_port_pair;
    else if (se_r)            a_nxt.tail = {16'd0, sport};
    else                      a_nxt.tail = {16'd0, dport};
    a_nxt.tb = tl;
  end

  logic        a_vld_r, b_vld_r, c_vld_r;
  item_t       a_r, b_r, c_r;
  logic [31:0] vs_a_r, vd_a_r, ms_b_r, md_b_r, ms_c_r, md_c_r;
  logic [31:0] xs, xd;

  assign xs = ms_b_r ^ {15'd0, ms_b_r[31:15]};
  assign xd = md_b_r ^ {15'd0, md_b_r[31:15]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_vld_r   <= acc;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_valid <= c_vld_r;
    end
  end

  // Stage A registers, then stages B and C: the two hash multiplies, one per stage for each port.
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    vs_a_r <= seed_of(so_seed, sp_seed, in_src_addr, in_dst_addr, proto, SALT_SRC);
    vd_a_r <= seed_of(do_seed, dp_seed, in_src_addr, in_dst_addr, proto, SALT_DST);
    b_r    <= a_r;
    ms_b_r <= vs_a_r * MIX_MUL_A;
    md_b_r <= vd_a_r * MIX_MUL_A;
    c_r    <= b_r;
    ms_c_r <= xs * MIX_MUL_B;
    md_c_r <= xd * MIX_MUL_B;
  end

  // Stage D: final fold, modulo, ghost compare and result selection.
  logic [15:0] gs, gd, so_orig, do_orig;
  logic        match;
  always_comb begin
    so_orig = c_r.op ? c_r.osrc : c_r.sport;
    do_orig = c_r.op ? c_r.odst : c_r.dport;
    gs = ghost_fin(ms_c_r ^ {16'd0, ms_c_r[31:16]}, so_orig);
    gd = ghost_fin(md_c_r ^ {16'd0, md_c_r[31:16]}, do_orig);
    match = (!c_r.se || (c_r.sport == gs)) && (!c_r.de || (c_r.dport == gd));
  end

  always_ff @(posedge clk) begin
    if (c_r.go && !c_r.op) begin
      out_status          <= ST_REWRITTEN;
      out_src_port_out    <= c_r.se ? gs : c_r.sport;
      out_dst_port_out    <= c_r.de ? gd : c_r.dport;
      out_total_len_out   <= c_r.tot_new;
      out_udp_len_out     <= c_r.udp_new;
      out_tail_out        <= c_r.tail;
      out_tail_bytes      <= c_r.tb;
      out_recalc_checksum <= 1'b0;
    end else if (c_r.go && match) begin
      out_status          <= ST_REWRITTEN;
      out_src_port_out    <= c_r.osrc;
      out_dst_port_out    <= c_r.odst;
      out_total_len_out   <= c_r.tot_new;
      out_udp_len_out     <= c_r.udp_new;
      out_tail_out        <= 32'd0;
      out_tail_bytes      <= c_r.tb;
      out_recalc_checksum <= 1'b1;
    end else begin
      out_status          <= c_r.drop ? ST_DROPPED : ST_UNCHANGED;
      out_src_port_out    <= c_r.sport;
      out_dst_port_out    <= c_r.dport;
      out_total_len_out   <= c_r.total;
      out_udp_len_out     <= c_r.l4;
      out_tail_out        <= 32'd0;
      out_tail_bytes      <= 3'd0;
      out_recalc_checksum <= 1'b0;
    end
  end

  // A result strobe is only raised when the request valid was held in stage C's register.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(c_vld_r)) else $error("result without request in pipe");
  // A checksum request only comes with a successful rewrite.
  a_rc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_recalc_checksum) |-> (out_status == ST_REWRITTEN))
    else $error("checksum request on unrewritten packet");
  // A packet left alone or dropped carries no tail.
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_REWRITTEN) |-> (out_tail_bytes == 3'd0 &&
      out_tail_out == 32'd0)) else $error("tail on unrewritten packet");
  // Restore results never carry an append tail.
  a_rtail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_recalc_checksum) |-> (out_tail_out == 32'd0))
    else $error("tail on restore");

endmodule
